FILE: rtl/core/ocx_pkg.sv
// shared types and constants for the order crossover core
package ocx_pkg;

  // field widths fixed by the item format
  localparam int CityW            = 6;
  localparam int CountW           = 7;
  localparam int InDataW          = 24;
  localparam int OutDataW         = 24;
  localparam int OutFieldsW       = 3 * CityW;

  // defaults and limits
  localparam int MaxCitiesDefault = 64;
  localparam int MinCities        = 2;
  localparam logic [CountW-1:0] CityCountReset = 7'd64;
  localparam int BitmapDepth      = 1 << CityW;

  // controller states
  typedef enum logic [4:0] {
    S_LOAD   = 5'b00001,
    S_SEG    = 5'b00010,
    S_FILL   = 5'b00100,
    S_SETTLE = 5'b01000,
    S_OUT    = 5'b10000
  } ocx_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // parent item transfer
    logic pair_start;  // final item of a pair: latch cuts, clear bitmaps
    logic seg_rd;      // read one segment position
    logic fill_rd;     // read one fill scan position
    logic out_arm;     // rewind address for readout
    logic out_run;     // readout in progress
    logic out_load;    // take one result into the output register
    logic cfg_we;      // city count write
  } ocx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_final;  // next item loads the last position
    logic seg_last;    // segment read at the cut end
    logic fill_last;   // last fill scan read
    logic primed;      // child read data matches the address
    logic out_free;    // output register can take a result
    logic out_last;    // readout address at the last position
  } ocx_status_t;

endpackage

FILE: rtl/core/ocx_ram.sv
// generic single write port ram with registered read
module ocx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/ocx_ctrl.sv
// sequencer for load, segment copy, fill scan and readout
module ocx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  ocx_pkg::ocx_status_t status_i,
  output ocx_pkg::ocx_cmd_t    cmd_o
);
  import ocx_pkg::*;

  ocx_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_LOAD);
  assign cfg_ready_o = 1'b1;

  // next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.cfg_we     = cfg_valid_i;
    case (state_q)
      S_LOAD: begin
        cmd_o.load       = in_valid_i;
        cmd_o.pair_start = in_valid_i && status_i.load_final;
        if (in_valid_i && status_i.load_final) begin
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        cmd_o.seg_rd = 1'b1;
        if (status_i.seg_last) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_rd = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_SETTLE;
        end
      end
      S_SETTLE: begin
        cmd_o.out_arm = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        cmd_o.out_run  = 1'b1;
        cmd_o.out_load = status_i.primed && status_i.out_free;
        if (status_i.primed && status_i.out_free && status_i.out_last) begin
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a completed pair always moves on to the segment copy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pair_start |=> state_q == S_SEG)
    else $error("pair start did not enter segment copy");
`endif

endmodule

FILE: rtl/core/ocx_datapath.sv
// parent and child stores, segment bitmaps, counters and output register
module ocx_datapath #(
  parameter int MAX_CITIES = ocx_pkg::MaxCitiesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ocx_pkg::ocx_cmd_t           cmd_i,
  output ocx_pkg::ocx_status_t        status_o,
  input  logic [ocx_pkg::CountW-1:0]  cfg_data_i,
  input  logic [ocx_pkg::CityW-1:0]   p1_city_i,
  input  logic [ocx_pkg::CityW-1:0]   p2_city_i,
  input  logic [ocx_pkg::CityW-1:0]   cut_start_i,
  input  logic [ocx_pkg::CityW-1:0]   cut_end_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [ocx_pkg::CityW-1:0]   out_pos_o,
  output logic [ocx_pkg::CityW-1:0]   out_c1_o,
  output logic [ocx_pkg::CityW-1:0]   out_c2_o,
  output logic                        out_last_o
);
  import ocx_pkg::*;

  localparam int AW   = $clog2(MAX_CITIES);
  localparam int CW   = AW + 1;
  localparam int CMPW = (CW > CountW) ? CW : CountW;

  logic [CountW-1:0]      city_count_q;
  logic [AW-1:0]          load_cnt_q;
  logic [AW-1:0]          lo_q, hi_q, addr_q, cnt_q, j1_q, j2_q, seg_addr_q;
  logic [CW-1:0]          fill1_q, fill2_q;
  logic [BitmapDepth-1:0] bm1_q, bm2_q;
  logic                   seg_vld_q, fill_vld_q, primed_q, out_valid_q;

  logic [CW-1:0]          n, nm1, free, addr_e, k_e, off;
  logic [CMPW-1:0]        cc_e, n_e, nm1_e, cs_e, ce_e, lo_e, ce_c, hi_e, pos_e;
  logic [AW-1:0]          nm1_a, k, lo_new, hi_new;
  logic [CityW-1:0]       p1_rd, p2_rd, c1_rd, c2_rd;
  logic                   acc1, acc2, in_seg, wr1, wr2;
  logic                   c1_we, c2_we;
  logic [AW-1:0]          c1_waddr, c2_waddr;
  logic [CityW-1:0]       c1_wdata, c2_wdata;

  // cyclic successor of a position
  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                             input logic [CW-1:0] cnt);
    logic [CW-1:0] q;
    q = CW'(p) + CW'(1);
    next_pos = (q >= cnt) ? '0 : q[AW-1:0];
  endfunction

  // active count clamped to the supported range
  always_comb begin
    cc_e  = CMPW'(city_count_q);
    if (cc_e < CMPW'(MinCities)) begin
      n_e = CMPW'(MinCities);
    end else if (cc_e > CMPW'(MAX_CITIES)) begin
      n_e = CMPW'(MAX_CITIES);
    end else begin
      n_e = cc_e;
    end
    n     = n_e[CW-1:0];
    nm1   = n - CW'(1);
    nm1_a = nm1[AW-1:0];
    nm1_e = CMPW'(nm1);
  end

  // cut clamping on the final item
  always_comb begin
    cs_e   = CMPW'(cut_start_i);
    ce_e   = CMPW'(cut_end_i);
    lo_e   = (cs_e > nm1_e) ? nm1_e : cs_e;
    ce_c   = (ce_e > nm1_e) ? nm1_e : ce_e;
    hi_e   = (ce_c < lo_e) ? lo_e : ce_c;
    lo_new = lo_e[AW-1:0];
    hi_new = hi_e[AW-1:0];
  end

  // fill start and number of free positions per child
  assign k    = next_pos(hi_q, n);
  assign free = n - CW'(hi_q) + CW'(lo_q) - CW'(1);

  // parent stores
  ocx_ram #(.WIDTH(CityW), .DEPTH(MAX_CITIES)) u_p1_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (load_cnt_q),
    .wdata_i (p1_city_i),
    .raddr_i (addr_q),
    .rdata_o (p1_rd)
  );

  ocx_ram #(.WIDTH(CityW), .DEPTH(MAX_CITIES)) u_p2_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (load_cnt_q),
    .wdata_i (p2_city_i),
    .raddr_i (addr_q),
    .rdata_o (p2_rd)
  );

  // fill decisions, one scan position per cycle
  assign acc1 = fill_vld_q && !bm1_q[p2_rd] && (fill1_q < free);
  assign acc2 = fill_vld_q && !bm2_q[p1_rd] && (fill2_q < free);

  // child write port: segment copy or cross fill
  always_comb begin
    if (seg_vld_q) begin
      c1_we    = 1'b1;
      c2_we    = 1'b1;
      c1_waddr = seg_addr_q;
      c2_waddr = seg_addr_q;
      c1_wdata = p1_rd;
      c2_wdata = p2_rd;
    end else begin
      c1_we    = acc1;
      c2_we    = acc2;
      c1_waddr = j1_q;
      c2_waddr = j2_q;
      c1_wdata = p2_rd;
      c2_wdata = p1_rd;
    end
  end

  // child stores
  ocx_ram #(.WIDTH(CityW), .DEPTH(MAX_CITIES)) u_c1_ram (
    .clk_i   (clk_i),
    .we_i    (c1_we),
    .waddr_i (c1_waddr),
    .wdata_i (c1_wdata),
    .raddr_i (addr_q),
    .rdata_o (c1_rd)
  );

  ocx_ram #(.WIDTH(CityW), .DEPTH(MAX_CITIES)) u_c2_ram (
    .clk_i   (clk_i),
    .we_i    (c2_we),
    .waddr_i (c2_waddr),
    .wdata_i (c2_wdata),
    .raddr_i (addr_q),
    .rdata_o (c2_rd)
  );

  // a position was written if it lies in the segment or in the filled run after it
  always_comb begin
    addr_e = CW'(addr_q);
    k_e    = CW'(k);
    off    = (addr_e >= k_e) ? (addr_e - k_e) : (addr_e + n - k_e);
    in_seg = (addr_q >= lo_q) && (addr_q <= hi_q);
    wr1    = in_seg || (off < fill1_q);
    wr2    = in_seg || (off < fill2_q);
    pos_e  = CMPW'(addr_q);
  end

  // counters, bitmaps and pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= CityCountReset;
      load_cnt_q   <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      addr_q       <= '0;
      cnt_q        <= '0;
      j1_q         <= '0;
      j2_q         <= '0;
      seg_addr_q   <= '0;
      fill1_q      <= '0;
      fill2_q      <= '0;
      bm1_q        <= '0;
      bm2_q        <= '0;
      seg_vld_q    <= 1'b0;
      fill_vld_q   <= 1'b0;
      primed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // configuration and load position
      if (cmd_i.cfg_we) begin
        city_count_q <= cfg_data_i;
        load_cnt_q   <= '0;
      end else if (cmd_i.load) begin
        load_cnt_q <= status_o.load_final ? '0 : load_cnt_q + AW'(1);
      end

      // shared scan address
      if (cmd_i.pair_start) begin
        lo_q    <= lo_new;
        hi_q    <= hi_new;
        addr_q  <= lo_new;
        fill1_q <= '0;
        fill2_q <= '0;
      end else if (cmd_i.seg_rd) begin
        if (addr_q == hi_q) begin
          addr_q <= k;
          cnt_q  <= '0;
          j1_q   <= k;
          j2_q   <= k;
        end else begin
          addr_q <= addr_q + AW'(1);
        end
      end else if (cmd_i.fill_rd) begin
        addr_q <= next_pos(addr_q, n);
        cnt_q  <= cnt_q + AW'(1);
      end else if (cmd_i.out_arm) begin
        addr_q <= '0;
      end else if (cmd_i.out_load) begin
        addr_q <= addr_q + AW'(1);
      end

      seg_vld_q  <= cmd_i.seg_rd;
      seg_addr_q <= addr_q;
      fill_vld_q <= cmd_i.fill_rd;

      // segment membership
      if (cmd_i.pair_start) begin
        bm1_q <= '0;
        bm2_q <= '0;
      end else if (seg_vld_q) begin
        bm1_q[p1_rd] <= 1'b1;
        bm2_q[p2_rd] <= 1'b1;
      end

      // fill write pointers
      if (acc1) begin
        j1_q    <= next_pos(j1_q, n);
        fill1_q <= fill1_q + CW'(1);
      end
      if (acc2) begin
        j2_q    <= next_pos(j2_q, n);
        fill2_q <= fill2_q + CW'(1);
      end

      // registered read data is valid in the cycle after the address holds
      primed_q <= cmd_i.out_run && !cmd_i.out_load;

      // output register valid
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pos_o  <= pos_e[CityW-1:0];
      out_c1_o   <= wr1 ? c1_rd : '0;
      out_c2_o   <= wr2 ? c2_rd : '0;
      out_last_o <= (addr_q == nm1_a);
    end
  end

  assign out_valid_o = out_valid_q;

  // status to the controller
  always_comb begin
    status_o            = '0;
    status_o.load_final = (load_cnt_q == nm1_a);
    status_o.seg_last   = (addr_q == hi_q);
    status_o.fill_last  = (cnt_q == nm1_a);
    status_o.primed     = primed_q;
    status_o.out_free   = !out_valid_q || out_ready_i;
    status_o.out_last   = (addr_q == nm1_a);
  end

`ifndef SYNTHESIS
  // fill never writes more than the free positions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_vld_q |-> (fill1_q <= free) && (fill2_q <= free))
    else $error("fill count beyond free positions");

  // segment copy and fill never share the child write port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(seg_vld_q && fill_vld_q))
    else $error("segment and fill writes overlap");

  // a result is only taken from settled child data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> primed_q && $past(cmd_i.out_run))
    else $error("result taken before child read settled");
`endif

endmodule

FILE: rtl/core/ordered_crossover_permutation_core.sv
// top level of the order crossover (ox1) core
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    parent cities, cut points
//  m_axis    out  m_axis_tvalid / m_axis_tready    position, child cities, tlast
//  cfg       in   cfg_valid_i / cfg_ready_o        city_count
//
//  parent items are accepted while loading; the final item of a pair starts the build.
//  build: a segment copy from clamped cut_start to clamped cut_end, a fill scan over
//  all n positions and a settle step, each read through the single parent store read port;
//  then one result per registered child store read, in position order, held by stalls.
//  no item is taken while a pair is built or read out; reset clears all control.
module ordered_crossover_permutation_core #(
  parameter int MAX_CITIES = ocx_pkg::MaxCitiesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // parent_one_city, parent_two_city, cut_start, cut_end
  input  logic [ocx_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // position, child_one_city, child_two_city, zero fill
  output logic [ocx_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ocx_pkg::CountW-1:0]    cfg_data_i
);
  import ocx_pkg::*;

  ocx_cmd_t         cmd;
  ocx_status_t      status;
  logic [CityW-1:0] out_pos, out_c1, out_c2;

  ocx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ocx_datapath #(.MAX_CITIES(MAX_CITIES)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_data_i  (cfg_data_i),
    .p1_city_i   (s_axis_tdata[CityW-1:0]),
    .p2_city_i   (s_axis_tdata[2*CityW-1:CityW]),
    .cut_start_i (s_axis_tdata[3*CityW-1:2*CityW]),
    .cut_end_i   (s_axis_tdata[4*CityW-1:3*CityW]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_pos_o   (out_pos),
    .out_c1_o    (out_c1),
    .out_c2_o    (out_c2),
    .out_last_o  (m_axis_tlast)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata = {{(OutDataW - OutFieldsW){1'b0}}, out_c2, out_c1, out_pos};

endmodule

FILE: test/tb_ordered_crossover_permutation_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the order crossover permutation core
module tb_ordered_crossover_permutation_core;

  localparam int          RandomItems  = 220;
  localparam int          SettleCycles = 16;
  localparam int unsigned CycleLimit   = 400000;
  localparam int          MaxCities    = ocx_pkg::MaxCitiesDefault;

  // one expected child row, as it leaves the master side
  typedef struct packed {
    logic [5:0] position;
    logic [5:0] city_one;
    logic [5:0] city_two;
    logic       last;
  } child_row_t;

  // how a parent pair is drawn
  typedef enum int {
    PERM_COMPACT,
    PERM_SPARSE,
    PARENT_NOISE
  } parent_style_e;

  // tracks parent loading, builds the expected children and checks the rows
  class ox1_child_tracker;
    bit [5:0]    parent_one [MaxCities];
    bit [5:0]    parent_two [MaxCities];
    int unsigned loaded;
    int unsigned city_count;
    child_row_t  rows_due [$];
    int unsigned mismatch_count;

    function new();
      loaded         = 0;
      city_count     = MaxCities;
      mismatch_count = 0;
    endfunction

    function int unsigned active_cities();
      if (city_count < ocx_pkg::MinCities) return ocx_pkg::MinCities;
      if (city_count > MaxCities) return MaxCities;
      return city_count;
    endfunction

    // a write drops any partly loaded pair
    function void set_city_count(bit [6:0] value);
      city_count = value;
      loaded     = 0;
    endfunction

    function int unsigned pending();
      return rows_due.size();
    endfunction

    function int unsigned wrap_next(int unsigned p, int unsigned n);
      return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    // ox1 on the stored parents, one expected row per position
    function void cross_parents(int unsigned n, int unsigned lo, int unsigned hi);
      bit          in_seg_one [64];
      bit          in_seg_two [64];
      bit [5:0]    child_one [MaxCities];
      bit [5:0]    child_two [MaxCities];
      int unsigned free_one, free_two, k, j1, j2;
      child_row_t  row;
      in_seg_one = '{default: 1'b0};
      in_seg_two = '{default: 1'b0};
      child_one  = '{default: 6'd0};
      child_two  = '{default: 6'd0};
      // keep each parent's own segment
      for (int unsigned m = lo; m <= hi; m++) begin
        in_seg_one[parent_one[m]] = 1'b1;
        in_seg_two[parent_two[m]] = 1'b1;
        child_one[m] = parent_one[m];
        child_two[m] = parent_two[m];
      end
      // cyclic fill from the other parent, starting past the cut end
      free_one = n - (hi - lo + 1);
      free_two = free_one;
      k  = wrap_next(hi, n);
      j1 = k;
      j2 = k;
      repeat (n) begin
        if (!in_seg_one[parent_two[k]] && free_one > 0) begin
          child_one[j1] = parent_two[k];
          j1 = wrap_next(j1, n);
          free_one--;
        end
        if (!in_seg_two[parent_one[k]] && free_two > 0) begin
          child_two[j2] = parent_one[k];
          j2 = wrap_next(j2, n);
          free_two--;
        end
        k = wrap_next(k, n);
      end
      for (int unsigned p = 0; p < n; p++) begin
        row.position = 6'(p);
        row.city_one = child_one[p];
        row.city_two = child_two[p];
        row.last     = (p + 1 == n);
        rows_due.insert(rows_due.size(), row);
      end
    endfunction

    // one accepted parent transfer
    function void note_parent_item(bit [23:0] data);
      int unsigned n, lo, hi;
      n = active_cities();
      if (loaded >= n) loaded = 0;
      parent_one[loaded] = data[5:0];
      parent_two[loaded] = data[11:6];
      if (loaded + 1 < n) begin
        loaded++;
        return;
      end
      loaded = 0;
      // clamp the cuts into the active range
      lo = data[17:12];
      hi = data[23:18];
      if (lo > n - 1) lo = n - 1;
      if (hi > n - 1) hi = n - 1;
      if (hi < lo) hi = lo;
      cross_parents(n, lo, hi);
    endfunction

    // one accepted result transfer against the oldest expected row
    function void check_row(logic [23:0] data, logic last_flag);
      child_row_t want;
      if (rows_due.size() == 0) begin
        $error("unexpected result: tdata %h tlast %b", data, last_flag);
        mismatch_count++;
        return;
      end
      want = rows_due.pop_front();
      if (data[5:0] !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, data[5:0]);
        mismatch_count++;
      end
      if (data[11:6] !== want.city_one) begin
        $error("child_one_city: expected %0d, got %0d", want.city_one, data[11:6]);
        mismatch_count++;
      end
      if (data[17:12] !== want.city_two) begin
        $error("child_two_city: expected %0d, got %0d", want.city_two, data[17:12]);
        mismatch_count++;
      end
      if (last_flag !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last_flag);
        mismatch_count++;
      end
      if (data[23:18] !== 6'd0) begin
        $error("tdata padding: expected 0, got %0d", data[23:18]);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // parent_one_city, parent_two_city, cut_start, cut_end
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // position, child_one_city, child_two_city, zero fill
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i    = '0;

  ox1_child_tracker tracker;
  bit               quiet_phase = 1'b0;
  int unsigned      items_sent  = 0;
  int unsigned      cycle_count = 0;

  ordered_crossover_permutation_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit [23:0] pack_item(bit [5:0] city_one, bit [5:0] city_two,
                                          bit [5:0] cut_start, bit [5:0] cut_end);
    return {cut_end, cut_start, city_two, city_one};
  endfunction

  // one parent transfer; valid stays high when the next item follows at once
  task automatic send_item(input bit [23:0] data);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_parent_item(data);
    items_sent++;
  endtask

  // stop sending, wait for every expected row, then let the core go idle
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_city_count(input bit [6:0] value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_city_count(value);
    cfg_valid_i <= 1'b0;
  endtask

  // a full pair; cuts only matter on the final transfer
  task automatic send_pair(input int unsigned n, input bit [5:0] one [MaxCities],
                           input bit [5:0] two [MaxCities],
                           input bit [5:0] cut_start, input bit [5:0] cut_end);
    for (int unsigned i = 0; i < n; i++) begin
      if (i + 1 == n) send_item(pack_item(one[i], two[i], cut_start, cut_end));
      else send_item(pack_item(one[i], two[i], 6'($urandom), 6'($urandom)));
    end
  endtask

  function automatic void draw_parents(input int unsigned n, input parent_style_e style,
                                       output bit [5:0] one [MaxCities],
                                       output bit [5:0] two [MaxCities]);
    int unsigned span, j;
    bit [5:0]    held;
    span = (style == PERM_COMPACT) ? n : MaxCities;
    for (int i = 0; i < MaxCities; i++) one[i] = 6'(i);
    for (int i = span - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      held = one[i]; one[i] = one[j]; one[j] = held;
    end
    // second parent holds the same labels in another order
    two = one;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      held = two[i]; two[i] = two[j]; two[j] = held;
    end
    // noise: labels repeat, mostly from a narrow range
    if (style == PARENT_NOISE) begin
      for (int unsigned i = 0; i < n; i++) begin
        one[i] = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3));
        two[i] = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3));
      end
    end
  endfunction

  function automatic void draw_cuts(input int unsigned n, output bit [5:0] cut_start,
                                    output bit [5:0] cut_end);
    if ($urandom_range(0, 9) < 7) begin
      cut_start = 6'($urandom_range(0, n - 1));
      cut_end   = 6'($urandom_range(cut_start, n - 1));
    end else begin
      cut_start = 6'($urandom_range(0, 63));
      cut_end   = 6'($urandom_range(0, 63));
    end
  endfunction

  // result side: random stalls, check every transfer
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_row(m_axis_tdata, m_axis_tlast);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin
    bit [5:0]      one [MaxCities];
    bit [5:0]      two [MaxCities];
    bit [5:0]      cut_start, cut_end;
    int unsigned   n, pairs, phase, sel, big_runs, directed_items;
    bit [6:0]      value;
    parent_style_e style;

    tracker = new();
    one = '{default: 6'd0};
    two = '{default: 6'd0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: four cities, ascending against descending, inner segment
    write_city_count(7'd4);
    for (int i = 0; i < 4; i++) begin
      one[i] = 6'(i);
      two[i] = 6'(3 - i);
    end
    send_pair(4, one, two, 6'd1, 6'd2);
    // top labels, segment covers everything so nothing is filled
    for (int i = 0; i < 4; i++) begin
      one[i] = 6'(63 - i);
      two[i] = 6'(60 + i);
    end
    send_pair(4, one, two, 6'd0, 6'd3);
    // cut start past the end, cut end below start: single kept position
    for (int i = 0; i < 4; i++) begin
      one[i] = 6'(i);
      two[i] = 6'((i + 2) % 4);
    end
    send_pair(4, one, two, 6'd63, 6'd0);
    // cut end past the last position
    send_pair(4, one, two, 6'd2, 6'd63);
    // parents that are not permutations give children with repeated labels
    for (int i = 0; i < 4; i++) begin
      one[i] = 6'd5;
      two[i] = 6'(i / 2);
    end
    send_pair(4, one, two, 6'd0, 6'd0);
    // half a pair, then a count write drops it
    send_item(pack_item(6'd9, 6'd8, 6'd0, 6'd0));
    send_item(pack_item(6'd7, 6'd6, 6'd0, 6'd0));
    // count below the minimum acts as two
    write_city_count(7'd0);
    one[0] = 6'd10; one[1] = 6'd20;
    two[0] = 6'd20; two[1] = 6'd10;
    send_pair(2, one, two, 6'd1, 6'd0);
    directed_items = items_sent;

    // random phases, each with its own count
    phase    = 0;
    big_runs = 0;
    while (items_sent - directed_items < RandomItems) begin
      sel = $urandom_range(0, 9);
      if (phase == 0) begin
        value = 7'd127;
        big_runs++;
      end else if (phase == 1) begin
        value = 7'd1;
      end else if (sel == 0 && big_runs < 2) begin
        value = 7'($urandom_range(64, 127));
        big_runs++;
      end else if (sel == 1) begin
        value = 7'($urandom_range(13, 40));
      end else if (sel == 2) begin
        value = 7'($urandom_range(0, 1));
      end else begin
        value = 7'($urandom_range(2, 12));
      end
      write_city_count(value);
      quiet_phase = ($urandom_range(0, 3) == 0);
      n     = tracker.active_cities();
      pairs = (n >= 32) ? 1 : $urandom_range(1, 4);
      repeat (pairs) begin
        sel = $urandom_range(0, 9);
        style = (sel < 6) ? PERM_COMPACT : (sel < 8) ? PERM_SPARSE : PARENT_NOISE;
        draw_parents(n, style, one, two);
        draw_cuts(n, cut_start, cut_end);
        send_pair(n, one, two, cut_start, cut_end);
        // occasionally hold off until the children are all out
        if ($urandom_range(0, 7) == 0) settle_block();
      end
      // sometimes leave a pair half loaded for the next write to drop
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, n - 1))
          send_item(pack_item(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom)));
      end
      phase++;
    end

    quiet_phase = 1'b0;
    settle_block();
    if (tracker.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
